>>> sv/polyline_path_interpolator_macros.svh
// ----------------------------------------------------------------------------
// polyline_path_interpolator_macros.svh
// Assertion macros shared by the checker of the path interpolator.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_PATH_INTERPOLATOR_MACROS_SVH
`define POLYLINE_PATH_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define PPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define PPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Types and constants of the polyline path interpolator.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int VERTEX_W     = 32;

    localparam int FRAME_W      = 25;
    localparam int SQRT_STEPS   = 25;
    localparam int DIV_STEPS    = 33;
    localparam int STEP_W       = 6;

    localparam logic [17:0] RATE_RESET  = 18'd15360;
    localparam logic [15:0] SPEED_RESET = 16'd1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_RATE = 2'd0,
        CFG_SPEED      = 2'd1,
        CFG_RESTART    = 2'd2
    } cfg_index_t;

    // Request opcodes
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    // Sequencer states
    typedef enum logic [18:0] {
        ST_IDLE = 19'h00001,
        ST_RD0  = 19'h00002,
        ST_RD1  = 19'h00004,
        ST_RD2  = 19'h00008,
        ST_MULX = 19'h00010,
        ST_MULY = 19'h00020,
        ST_SUM  = 19'h00040,
        ST_SQRT = 19'h00080,
        ST_MULR = 19'h00100,
        ST_DSET = 19'h00200,
        ST_DIVF = 19'h00400,
        ST_FRM  = 19'h00800,
        ST_DIVX = 19'h01000,
        ST_VX   = 19'h02000,
        ST_DIVY = 19'h04000,
        ST_VY   = 19'h08000,
        ST_POSX = 19'h10000,
        ST_POSY = 19'h20000,
        ST_OUT  = 19'h40000
    } state_t;

endpackage

>>> sv/polyline_path_interpolator.sv
// ----------------------------------------------------------------------------
// polyline_path_interpolator
// Walks a stored polyline at constant speed, at most one position per frame tick.
// ----------------------------------------------------------------------------
// A load request stores one vertex if the store has room. A frame tick inside
// a segment runs the shared multiplier once for x and once for y. A tick
// that opens a segment does two vertex reads, two squares, a 25-step
// bit-serial square root, a multiply, and three 33-step restoring divisions
// (frame count, x and y velocity) all on one shared divider. The block is
// not ready while a tick is in work; a finished position waits in the output
// register while the next request is taken.
module polyline_path_interpolator
    import ppi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_wdata,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // vertex_x[15:0], vertex_y[31:16]
    input  logic [1:0]  s_tuser,   // opcode[0], first_vertex[1]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pos_x[23:0], pos_y[47:24]
    output logic        m_tlast    // path_done
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         seg_reg, seg_next;
    logic [FRAME_W-1:0]        frame_reg, frame_next;
    logic [FRAME_W-1:0]        seg_frames_reg, seg_frames_next;
    logic signed [15:0]        start_x_reg, start_x_next;
    logic signed [15:0]        start_y_reg, start_y_next;
    logic signed [31:0]        vel_x_reg, vel_x_next;
    logic signed [31:0]        vel_y_reg, vel_y_next;
    logic                      armed_reg, armed_next;
    logic signed [16:0]        dx_reg, dx_next;
    logic signed [16:0]        dy_reg, dy_next;
    logic [33:0]               len2_reg, len2_next;
    logic [49:0]               sq_n_reg, sq_n_next;
    logic [25:0]               sq_rem_reg, sq_rem_next;
    logic [24:0]               root_reg, root_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [24:0]               div_rem_reg, div_rem_next;
    logic [32:0]               div_quo_reg, div_quo_next;
    logic [24:0]               div_den_reg, div_den_next;
    logic signed [58:0]        prod_reg;
    logic [23:0]               pos_x_reg, pos_x_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [47:0]               m_tdata_reg, m_tdata_next;
    logic                      m_tlast_reg, m_tlast_next;
    logic [17:0]               rate_reg;
    logic [15:0]               speed_reg;
    logic                      restart_reg;

    // ------------------------------------------------------------------
    // Vertex store
    // ------------------------------------------------------------------
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VERTEX_W-1:0]       ram_rdata;

    ppi_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [23:0] sat24(input logic signed [58:0] p);
        logic signed [50:0] q;
        begin
            q = p[58:8];
            if (q[50:23] == {28{q[50]}})
                sat24 = q[23:0];
            else if (q[50])
                sat24 = 24'h800000;
            else
                sat24 = 24'h7FFFFF;
        end
    endfunction

    function automatic logic signed [31:0] vel_sat(input logic [32:0] mag,
                                                   input logic neg,
                                                   input logic zero);
        logic [32:0] nmag;
        begin
            nmag = ~mag + 33'd1;
            if (zero)
                vel_sat = 32'sd0;
            else if (!neg)
                vel_sat = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            else
                vel_sat = (mag > 33'h080000000) ? 32'h80000000 : nmag[31:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Shared multiplier, operand select
    // ------------------------------------------------------------------
    logic signed [25:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (state_reg)
            ST_MULX:
            begin
                mul_a = 26'(dx_reg);
                mul_b = 33'(dx_reg);
            end
            ST_MULY:
            begin
                mul_a = 26'(dy_reg);
                mul_b = 33'(dy_reg);
            end
            ST_MULR:
            begin
                mul_a = $signed({8'd0, rate_reg});
                mul_b = $signed({8'd0, root_reg});
            end
            ST_POSX:
            begin
                mul_a = $signed({1'b0, frame_reg});
                mul_b = 33'(vel_x_reg);
            end
            ST_POSY:
            begin
                mul_a = $signed({1'b0, frame_reg});
                mul_b = 33'(vel_y_reg);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // ------------------------------------------------------------------
    // Square root and divider step logic
    // ------------------------------------------------------------------
    logic [27:0] sq_trial;
    logic [27:0] sq_sub;
    logic        sq_ge;
    logic [25:0] dv_trial;
    logic        dv_ge;
    logic [25:0] dv_diff;

    assign sq_trial = {sq_rem_reg, sq_n_reg[49:48]};
    assign sq_sub   = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_trial >= sq_sub);
    assign dv_trial = {div_rem_reg, div_quo_reg[32]};
    assign dv_ge    = (dv_trial >= {1'b0, div_den_reg});
    assign dv_diff  = dv_trial - {1'b0, div_den_reg};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic               s_accept;
    logic [CNT_W-1:0]   seg_p1;
    logic [CNT_W-1:0]   seg_eff;
    logic [15:0]        spd;
    logic [33:0]        frames_raw;
    logic [FRAME_W-1:0] frames_sat;
    logic               is_last_seg;
    logic [FRAME_W:0]   frame_p1;
    logic [16:0]        abs_d;
    logic signed [58:0] pos_y_prod;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign seg_p1      = {1'b0, seg_reg} + CNT_W'(1);
    assign seg_eff     = (seg_p1 >= count_reg) ? '0 : {1'b0, seg_reg};
    assign spd         = (speed_reg == 16'd0) ? 16'd1 : speed_reg;
    assign is_last_seg = ({1'b0, seg_reg} == count_reg - CNT_W'(2));
    assign frames_raw  = {1'b0, div_quo_reg} + {33'd0, is_last_seg};
    assign frames_sat  = (frames_raw > 34'h1FFFFFF) ? {FRAME_W{1'b1}}
                                                   : frames_raw[FRAME_W-1:0];
    assign frame_p1    = {1'b0, frame_reg} + (FRAME_W+1)'(1);
    assign pos_y_prod  = prod_reg + $signed({{27{start_y_reg[15]}}, start_y_reg, 16'd0});

    // store write on a load request
    assign ram_we    = s_accept && (s_tuser[0] == OP_LOAD) &&
                       (s_tuser[1] || (count_reg < CNT_W'(MAX_VERTICES)));
    assign ram_waddr = s_tuser[1] ? '0 : count_reg[ADDR_W-1:0];
    assign ram_raddr = (state_reg == ST_RD0) ? seg_reg : seg_p1[ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        seg_next        = seg_reg;
        frame_next      = frame_reg;
        seg_frames_next = seg_frames_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        vel_x_next      = vel_x_reg;
        vel_y_next      = vel_y_reg;
        armed_next      = armed_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        len2_next       = len2_reg;
        sq_n_next       = sq_n_reg;
        sq_rem_next     = sq_rem_reg;
        root_next       = root_reg;
        step_next       = step_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        div_den_next    = div_den_reg;
        pos_x_next      = pos_x_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        abs_d           = '0;

        // output register drains independently
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser[0] == OP_LOAD)
                    begin
                        if (s_tuser[1])
                        begin
                            count_next = CNT_W'(1);
                            armed_next = 1'b1;
                        end
                        else if (count_reg < CNT_W'(MAX_VERTICES))
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        seg_next   = '0;
                        frame_next = '0;
                    end
                    else if (armed_reg && (count_reg >= CNT_W'(2)))
                    begin
                        seg_next   = seg_eff[ADDR_W-1:0];
                        state_next = (frame_reg == '0) ? ST_RD0 : ST_POSX;
                    end
                end
            end
            ST_RD0: state_next = ST_RD1;
            ST_RD1:
            begin
                start_x_next = ram_rdata[15:0];
                start_y_next = ram_rdata[31:16];
                state_next   = ST_RD2;
            end
            ST_RD2:
            begin
                dx_next    = 17'($signed(ram_rdata[15:0])) - 17'(start_x_reg);
                dy_next    = 17'($signed(ram_rdata[31:16])) - 17'(start_y_reg);
                state_next = ST_MULX;
            end
            ST_MULX: state_next = ST_MULY;
            ST_MULY:
            begin
                len2_next  = prod_reg[33:0];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sq_n_next   = {len2_reg + prod_reg[33:0], 16'd0};
                sq_rem_next = '0;
                root_next   = '0;
                step_next   = '0;
                state_next  = ST_SQRT;
            end
            // one result bit of the root per cycle
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_rem_next = 26'(sq_trial - sq_sub);
                    root_next   = {root_reg[23:0], 1'b1};
                end
                else
                begin
                    sq_rem_next = sq_trial[25:0];
                    root_next   = {root_reg[23:0], 1'b0};
                end
                sq_n_next = {sq_n_reg[47:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_MULR;
                end
            end
            ST_MULR: state_next = ST_DSET;
            // frames = floor((rate * len) / 2^16 / speed)
            ST_DSET:
            begin
                div_quo_next = {6'd0, prod_reg[42:16]};
                div_den_next = {9'd0, spd};
                div_rem_next = '0;
                step_next    = '0;
                state_next   = ST_DIVF;
            end
            ST_DIVF, ST_DIVX, ST_DIVY:
            begin
                if (dv_ge)
                begin
                    div_rem_next = dv_diff[24:0];
                end
                else
                begin
                    div_rem_next = dv_trial[24:0];
                end
                div_quo_next = {div_quo_reg[31:0], dv_ge};
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    if (state_reg == ST_DIVF)
                        state_next = ST_FRM;
                    else if (state_reg == ST_DIVX)
                        state_next = ST_VX;
                    else
                        state_next = ST_VY;
                end
            end
            ST_FRM:
            begin
                seg_frames_next = frames_sat;
                if (frames_sat == '0)
                begin
                    // empty segment: skip with no result
                    seg_next = seg_p1[ADDR_W-1:0];
                    if (seg_p1 == count_reg - CNT_W'(1))
                    begin
                        seg_next   = '0;
                        frame_next = '0;
                        armed_next = restart_reg;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    abs_d        = dx_reg[16] ? 17'(-dx_reg) : dx_reg;
                    div_quo_next = {abs_d, 16'd0};
                    div_den_next = frames_sat - FRAME_W'(1);
                    div_rem_next = '0;
                    step_next    = '0;
                    state_next   = ST_DIVX;
                end
            end
            ST_VX:
            begin
                vel_x_next   = vel_sat(div_quo_reg, dx_reg[16],
                                       seg_frames_reg <= FRAME_W'(1));
                abs_d        = dy_reg[16] ? 17'(-dy_reg) : dy_reg;
                div_quo_next = {abs_d, 16'd0};
                div_rem_next = '0;
                step_next    = '0;
                state_next   = ST_DIVY;
            end
            ST_VY:
            begin
                vel_y_next = vel_sat(div_quo_reg, dy_reg[16],
                                     seg_frames_reg <= FRAME_W'(1));
                state_next = ST_POSX;
            end
            ST_POSX: state_next = ST_POSY;
            ST_POSY:
            begin
                pos_x_next = sat24(prod_reg +
                             $signed({{27{start_x_reg[15]}}, start_x_reg, 16'd0}));
                state_next = ST_OUT;
            end
            // hand the position over and advance the walk
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {sat24(pos_y_prod), pos_x_reg};
                    m_tlast_next  = 1'b0;
                    if (frame_p1 >= {1'b0, seg_frames_reg})
                    begin
                        frame_next = '0;
                        seg_next   = seg_p1[ADDR_W-1:0];
                        if (seg_p1 >= count_reg - CNT_W'(1))
                        begin
                            seg_next     = '0;
                            armed_next   = restart_reg;
                            m_tlast_next = 1'b1;
                        end
                    end
                    else
                    begin
                        frame_next = frame_p1[FRAME_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            seg_reg        <= '0;
            frame_reg      <= '0;
            seg_frames_reg <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            armed_reg      <= 1'b0;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            seg_reg        <= seg_next;
            frame_reg      <= frame_next;
            seg_frames_reg <= seg_frames_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            vel_x_reg      <= vel_x_next;
            vel_y_reg      <= vel_y_next;
            armed_reg      <= armed_next;
            step_reg       <= step_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        len2_reg    <= len2_next;
        sq_n_reg    <= sq_n_next;
        sq_rem_reg  <= sq_rem_next;
        root_reg    <= root_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        pos_x_reg   <= pos_x_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= RATE_RESET;
            speed_reg   <= SPEED_RESET;
            restart_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_RATE: rate_reg    <= cfg_wdata;
                CFG_SPEED:      speed_reg   <= cfg_wdata[15:0];
                CFG_RESTART:    restart_reg <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> sv/ppi_ram.sv
// ----------------------------------------------------------------------------
// ppi_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/ppi_checker.sv
// ----------------------------------------------------------------------------
// ppi_checker
// Port-level assertions for the polyline path interpolator.
// ----------------------------------------------------------------------------
`include "polyline_path_interpolator_macros.svh"

module ppi_checker
    import ppi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [17:0] cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // stalled result stays offered
    `PPI_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped")

    // stalled result keeps its payload
    `PPI_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // a vertex load never creates a result
    `PPI_ASSERT_NEXT(a_load_quiet,
        s_tvalid && s_tready && (s_tuser[0] == OP_LOAD) && !m_tvalid,
        !m_tvalid, "load produced a result")

    // a new result only follows a busy cycle of the sequencer
    `PPI_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), !$past(s_tready),
        "result appeared without tick processing")

endmodule

bind polyline_path_interpolator ppi_checker u_ppi_checker (.*);

>>> verif/ppi_path_checker.sv
// ----------------------------------------------------------------------------
// ppi_path_checker
// Predicts and checks the positions of the polyline path interpolator.
// ----------------------------------------------------------------------------
// Watches the configuration port and both streams. Every accepted request
// updates a private copy of the path walk, and every tick that yields a
// position queues the expected value. Each accepted result is compared
// field by field with the oldest queued position.
module ppi_path_checker
    import ppi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned FRAMES_SAT = 64'h1FF_FFFF;

    typedef struct packed {
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic        done;
    } position_t;

    position_t   positions_due[$];

    // walk state
    logic [31:0] vertices [MAX_VERTICES];
    int unsigned num_vertices;
    int unsigned seg_idx;
    int unsigned frame_idx;
    int unsigned seg_frames;
    int          start_x, start_y;
    int          vel_x, vel_y;
    bit          walking;

    // register copies
    logic [17:0] rate_q8;
    logic [15:0] speed_reg;
    bit          restart;

    assign pending = positions_due.size();

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int seg_velocity(longint d, int unsigned frames);
        longint q;
        if (frames <= 1) return 0;
        q = (d * 65536) / longint'(frames - 1);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return int'(q);
    endfunction

    function automatic logic [23:0] interp(int s, int v, int unsigned i);
        longint p, q;
        p = longint'(s) * 65536 + longint'(i) * longint'(v);
        q = p >>> 8;    // floor division by 256
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        return q[23:0];
    endfunction

    function automatic void end_of_path();
        seg_idx = 0;
        frame_idx = 0;
        if (!restart) walking = 0;
    endfunction

    // one accepted request: load a vertex or advance the walk by a frame
    function automatic void advance(logic [1:0] user, logic [31:0] data);
        longint          dx, dy;
        longint unsigned len2, len_q8, spd, frames;
        position_t       p;
        if (user[0] == OP_LOAD)
        begin
            if (user[1])
            begin
                num_vertices = 0;
                walking = 1;
            end
            if (num_vertices < MAX_VERTICES)
            begin
                vertices[num_vertices] = data;
                num_vertices++;
            end
            seg_idx = 0;
            frame_idx = 0;
            return;
        end
        if (!walking || num_vertices < 2) return;
        if (seg_idx + 1 >= num_vertices) seg_idx = 0;
        if (frame_idx == 0)
        begin
            start_x = $signed(vertices[seg_idx][15:0]);
            start_y = $signed(vertices[seg_idx][31:16]);
            dx = longint'($signed(vertices[seg_idx + 1][15:0])) - start_x;
            dy = longint'($signed(vertices[seg_idx + 1][31:16])) - start_y;
            len2 = dx * dx + dy * dy;
            len_q8 = int_sqrt(len2 << 16);
            spd = (speed_reg == 0) ? 1 : speed_reg;
            frames = (longint'(rate_q8) * len_q8) / (spd << 16);
            if (seg_idx == num_vertices - 2) frames++;
            if (frames > FRAMES_SAT) frames = FRAMES_SAT;
            seg_frames = frames;
            if (seg_frames == 0)
            begin
                // empty segment: skip without a position
                seg_idx++;
                if (seg_idx == num_vertices - 1) end_of_path();
                return;
            end
            vel_x = seg_velocity(dx, seg_frames);
            vel_y = seg_velocity(dy, seg_frames);
        end
        p.pos_x = interp(start_x, vel_x, frame_idx);
        p.pos_y = interp(start_y, vel_y, frame_idx);
        p.done = 0;
        frame_idx++;
        if (frame_idx >= seg_frames)
        begin
            frame_idx = 0;
            seg_idx++;
            if (seg_idx >= num_vertices - 1)
            begin
                end_of_path();
                p.done = 1;
            end
        end
        positions_due.push_back(p);
    endfunction

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // monitor and compare
    always @(posedge clk or negedge rst_n)
    begin
        position_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            positions_due.delete();
            num_vertices = 0;
            seg_idx = 0;
            frame_idx = 0;
            seg_frames = 0;
            start_x = 0;
            start_y = 0;
            vel_x = 0;
            vel_y = 0;
            walking = 0;
            rate_q8 = RATE_RESET;
            speed_reg = SPEED_RESET;
            restart = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_RATE: rate_q8 = cfg_wdata;
                    CFG_SPEED:      speed_reg = cfg_wdata[15:0];
                    CFG_RESTART:    restart = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (positions_due.size() == 0)
                    report($sformatf("unexpected position %h last %b", m_tdata, m_tlast));
                else
                begin
                    want = positions_due.pop_front();
                    if (m_tdata[23:0] !== want.pos_x)
                        report($sformatf("pos_x %h, want %h", m_tdata[23:0], want.pos_x));
                    if (m_tdata[47:24] !== want.pos_y)
                        report($sformatf("pos_y %h, want %h", m_tdata[47:24], want.pos_y));
                    if (m_tlast !== want.done)
                        report($sformatf("path_done %b, want %b", m_tlast, want.done));
                end
            end
            if (s_tvalid && s_tready)
                advance(s_tuser, s_tdata);
        end
    end

endmodule

>>> verif/tb_polyline_path_interpolator.sv
// ----------------------------------------------------------------------------
// tb_polyline_path_interpolator
// Stimulus and verdict for the polyline path interpolator.
// ----------------------------------------------------------------------------
// Loads directed and random paths, sends frame ticks, and varies the frame
// rate, speed and restart setting between phases while the block is idle.
// Both stream sides idle at random; the path checker compares every position.
module tb_polyline_path_interpolator
    import ppi_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [17:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // vertex_x[15:0], vertex_y[31:16]
    logic [1:0]  s_tuser;   // opcode[0], first_vertex[1]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // pos_x[23:0], pos_y[47:24]
    logic        m_tlast;   // path_done

    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_kick;
    int          quiet_cycles;

    polyline_path_interpolator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ppi_path_checker path_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge clk)
    begin
        int  hold_left;
        bit  hold_used;
        if (hold_kick && !hold_used)
        begin
            hold_used = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(opcode_t op, bit first, logic [15:0] x, logic [15:0] y);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {first, op};
        s_tdata  <= {y, x};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic tick();
        send(OP_TICK, $urandom_range(0, 1), $urandom, $urandom);
    endtask

    // stop sending and wait until every position has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [17:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic setup(logic [17:0] rate, logic [15:0] spd, bit rst_walk);
        write_reg(CFG_FRAME_RATE, rate);
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_RESTART, rst_walk);
    endtask

    function automatic logic [15:0] coord(int mag);
        return 16'($signed($urandom_range(0, 2 * mag)) - mag);
    endfunction

    initial
    begin
        int rate, spd, mag, n, ticks, sent, choice;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_FRAME_RATE;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        hold_kick      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty path, one vertex, extreme diagonal, append
        setup(18'd256, 16'd65535, 1'b0);
        tick();
        send(OP_LOAD, 1, 16'h1234, 16'hABCD);
        tick();
        send(OP_LOAD, 1, 16'h7FFF, 16'h7FFF);
        send(OP_LOAD, 0, 16'h8000, 16'h8000);
        tick();
        tick();
        send(OP_LOAD, 0, 16'h0000, 16'hFFFF);
        tick();
        tick();
        tick();
        // empty first segment, then a one-frame last segment, then disarmed
        send(OP_LOAD, 1, 16'd0, 16'd0);
        send(OP_LOAD, 0, 16'd1, 16'd0);
        send(OP_LOAD, 0, 16'd2, 16'd0);
        tick();
        tick();
        drain();

        // frame count saturation with speed zero, restart on
        setup(18'd256000, 16'd0, 1'b1);
        send(OP_LOAD, 1, 16'h8000, 16'h0000);
        send(OP_LOAD, 0, 16'h7FFF, 16'h0000);
        tick();
        tick();
        tick();
        drain();

        // full store: more vertices than the block holds
        setup(18'd15360, 16'd65535, 1'b1);
        send(OP_LOAD, 1, coord(100), coord(100));
        for (int k = 0; k < MAX_VERTICES + 2; k++)
            send(OP_LOAD, 0, coord(100), coord(100));
        for (int k = 0; k < 20; k++)
            tick();
        drain();

        // random phases
        for (int ph = 0; ph < 9; ph++)
        begin
            send_idle_pct  = (ph < 3) ? 30 : (ph < 6) ? 55 : 0;
            recv_stall_pct = (ph < 3) ? 55 : (ph < 6) ? 30 : 0;
            choice = $urandom_range(0, 3);
            case (choice)
                0: begin rate = 256;   spd = $urandom_range(1, 65535); mag = 32767; end
                1: begin rate = 15360; spd = 65535; mag = 32767; end
                2: begin rate = 256000; spd = 65535; mag = 2047; end
                default: begin rate = $urandom_range(256, 256000); spd = 65535; mag = 255; end
            endcase
            setup(18'(rate), 16'(spd), $urandom_range(0, 1));
            sent = 0;
            while (sent < 150)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // noise: stray ticks and appended vertices
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        if ($urandom_range(0, 1)) tick();
                        else send(OP_LOAD, 0, $urandom, $urandom);
                    sent += n;
                end
                else
                begin
                    n = $urandom_range(2, 6);
                    for (int k = 0; k < n; k++)
                        send(OP_LOAD, k == 0, coord(mag), coord(mag));
                    if (ph == 4 && !hold_kick)
                        hold_kick <= 1'b1;
                    ticks = $urandom_range(1, 60);
                    for (int k = 0; k < ticks; k++)
                        tick();
                    sent += n + ticks;
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
